>>> hw/rtl/tbps_pkg.sv
// Shared types and constants for the token bucket packet shaper.
package tbps_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned TOK_W   = 8;
  localparam int unsigned STAT_W  = 3;

  localparam logic [TOK_W-1:0] DEPTH_RESET = 8'd10;

  typedef enum logic [0:0] {
    KIND_TICK   = 1'b0,
    KIND_PACKET = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_PKT_DROP   = 3'd1,
    ST_RELEASED   = 3'd2,
    ST_TOK_STORED = 3'd3,
    ST_TOK_DROP   = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  // One queued packet.
  typedef struct packed {
    logic [TOK_W-1:0] need;
    logic [ID_W-1:0]  id;
  } entry_t;

  // One input event.
  typedef struct packed {
    kind_e            kind;
    logic [TOK_W-1:0] tokens_needed;
    logic [ID_W-1:0]  packet_id;
  } event_t;

  // Result fields that do not depend on the queue depth.
  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  released_id;
    logic [TOK_W-1:0] released_tokens;
    logic [TOK_W-1:0] token_level;
  } result_t;

endpackage

>>> hw/rtl/token_bucket_packet_shaper_unit.sv
// Top level of the token bucket packet shaper.
//
// Slave stream: one beat per event. tuser is the kind (tick or packet),
// tdata carries packet id and tokens needed. Master stream: one beat per
// event with the status in tuser and the released packet, bucket level and
// queue count in tdata. The cfg channel writes the bucket depth (reset 10);
// write it only while no event is in flight.
//
// Path: input register, then decision logic into the output register.
// Throughput: one event per cycle while m_axis_tready holds, set by the
// single decision pass; the head-of-queue entry is prefetched from the
// queue memory through its registered read port.
//
// Reset clears the bucket level and empties the queue; the queue memory
// itself is not cleared. When the receiver stalls, the held output beat
// stays put, one more event waits in the input register, and then
// s_axis_tready drops.
module token_bucket_packet_shaper_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration: bucket depth.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tbps_pkg::TOK_W-1:0]            cfg_data_i,
  // Events in.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] packet_id, [23:16] tokens_needed
  input  logic [23:0]                           s_axis_tdata,
  // [0] kind
  input  logic [0:0]                            s_axis_tuser,
  // Results out.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [15:0] released_id, [23:16] released_tokens, [31:24] token_level,
  // [32+CW-1:32] queue_count, rest zero
  output logic [((32 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // [2:0] status
  output logic [tbps_pkg::STAT_W-1:0]           m_axis_tuser
);
  import tbps_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OUT_DW = ((32 + CNT_W + 7) / 8) * 8;

  logic [TOK_W-1:0] depth_q;
  logic             in_valid_q;
  event_t           in_q;
  logic             out_valid_q;
  result_t          out_res_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             fire;
  result_t          res;
  logic [CNT_W-1:0] res_cnt;

  // Depth register: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_valid_i) begin
      depth_q <= cfg_data_i;
    end
  end

  // Process the held event when the output register is free or draining.
  assign fire          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.kind          <= kind_e'(s_axis_tuser[0]);
      in_q.packet_id     <= s_axis_tdata[15:0];
      in_q.tokens_needed <= s_axis_tdata[23:16];
    end
  end

  tbps_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .evt_i   (in_q),
    .depth_i (depth_q),
    .res_o   (res),
    .count_o (res_cnt)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
      out_cnt_q <= res_cnt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.status;
  assign m_axis_tdata  = OUT_DW'({out_cnt_q, out_res_q.token_level,
                                  out_res_q.released_tokens, out_res_q.released_id});

endmodule

>>> hw/rtl/tbps_store.sv
// Packet queue storage: one write port, one registered write-first read port.
module tbps_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     wa_i,
  input  tbps_pkg::entry_t  wd_i,
  input  logic [AW-1:0]     ra_i,
  output tbps_pkg::entry_t  rd_o
);
  import tbps_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
  end

  // Write-first so a packet pushed into an empty queue is the head next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i && (wa_i == ra_i)) begin
      rd_q <= wd_i;
    end else begin
      rd_q <= mem_q[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> hw/rtl/tbps_core.sv
// Bucket level, queue pointers and the per-event decision logic.
module tbps_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PTR_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  tbps_pkg::event_t              evt_i,
  input  logic [tbps_pkg::TOK_W-1:0]    depth_i,
  output tbps_pkg::result_t             res_o,
  output logic [CNT_W-1:0]              count_o
);
  import tbps_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [TOK_W-1:0] level_q, level_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  entry_t           head_entry;
  entry_t           new_entry;
  logic [TOK_W:0]   level_inc;
  logic [TOK_W-1:0] level_tick;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign new_entry.id   = evt_i.packet_id;
  assign new_entry.need = evt_i.tokens_needed;
  assign level_inc      = {1'b0, level_q} + (TOK_W+1)'(1);
  assign level_tick     = level_inc[TOK_W-1:0];

  always_comb begin
    level_d = level_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    push    = 1'b0;
    res_o   = '{status: ST_QUEUED, released_id: '0, released_tokens: '0,
                token_level: '0};
    if (fire_i) begin
      if (evt_i.kind == KIND_TICK) begin
        if (level_inc > {1'b0, depth_i}) begin
          res_o.status = ST_TOK_DROP;
        end else begin
          level_d      = level_tick;
          res_o.status = ST_TOK_STORED;
          if ((count_q != '0) && (head_entry.need <= level_tick)) begin
            res_o.status          = ST_RELEASED;
            res_o.released_id     = head_entry.id;
            res_o.released_tokens = head_entry.need;
            level_d               = level_tick - head_entry.need;
            head_d                = ptr_next(head_q);
            count_d               = count_q - CNT_W'(1);
          end
        end
      end else begin
        if (evt_i.tokens_needed > depth_i) begin
          res_o.status = ST_PKT_DROP;
        end else if (count_q == CNT_FULL) begin
          res_o.status = ST_FULL;
        end else begin
          push    = 1'b1;
          tail_d  = ptr_next(tail_q);
          count_d = count_q + CNT_W'(1);
          // Alone in the queue with enough tokens: straight through.
          if ((count_q == '0) && (level_q >= evt_i.tokens_needed)) begin
            res_o.status          = ST_RELEASED;
            res_o.released_id     = evt_i.packet_id;
            res_o.released_tokens = evt_i.tokens_needed;
            level_d               = level_q - evt_i.tokens_needed;
            head_d                = ptr_next(head_q);
            count_d               = count_q;
          end
        end
      end
    end
    res_o.token_level = level_d;
  end

  assign count_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      level_q <= level_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  tbps_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_store (
    .clk_i (clk_i),
    .we_i  (push),
    .wa_i  (tail_q),
    .wd_i  (new_entry),
    .ra_i  (head_d),
    .rd_o  (head_entry)
  );

endmodule
